>>> hdl/length_prefixed_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame parser
// Clocked on clock and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH

// property must hold at every edge
`define LPFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen
`define LPFP_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> hdl/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared widths and transaction types for the frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;

   typedef struct packed {
      logic              vld;
      logic [BYTE_W-1:0] data;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] channel;
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_valid;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_last;
   } result_type;

endpackage

>>> hdl/lpfp_in_reg.sv
// ----------------------------------------------------------------------------
// lpfp_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module lpfp_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lpfp_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                      pop,
   output lpfp_pkg::item_type        item
);
   import lpfp_pkg::*;

   logic              vld_ff, vld_in;
   logic [BYTE_W-1:0] data_ff;

   assign req_ready = !vld_ff || pop;
   assign vld_in    = (req_valid && req_ready) || (vld_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_rx_byte;
      end
   end

   assign item.vld  = vld_ff;
   assign item.data = data_ff;

endmodule

>>> hdl/lpfp_parser.sv
// ----------------------------------------------------------------------------
// lpfp_parser
// Header/payload state machine and result register.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_parser_assert.svh"

module lpfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  lpfp_pkg::item_type    item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpfp_pkg::result_type  rsp
);
   import lpfp_pkg::*;

   typedef enum logic [3:0] {
      PH_CHANNEL = 4'b0001,
      PH_LEN_HI  = 4'b0010,
      PH_LEN_LO  = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] chan_ff, chan_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              out_vld_ff, out_vld_in;
   result_type        out_ff, res;
   logic              emit, out_free, last;

   assign out_free = !out_vld_ff || rsp_ready;
   assign last     = (left_ff <= LEN_W'(1));

   always_comb begin
      phase_in = phase_ff;
      chan_in  = chan_ff;
      len_in   = len_ff;
      left_in  = left_ff;
      emit     = 1'b0;
      res.channel      = chan_ff;
      res.payload_byte = item.data;
      res.byte_valid   = 1'b1;
      res.frame_length = len_ff;
      res.frame_last   = last;
      case (phase_ff)
         PH_CHANNEL: begin
            chan_in  = item.data;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = {item.data, {BYTE_W{1'b0}}};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = {len_ff[LEN_W-1:BYTE_W], item.data};
            res.frame_length = len_in;
            if (len_in == '0) begin
               left_in  = '0;
               phase_in = PH_CHANNEL;
               emit     = 1'b1;
               res.payload_byte = '0;
               res.byte_valid   = 1'b0;
               res.frame_last   = 1'b1;
            end else begin
               left_in  = len_in;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            emit    = 1'b1;
            left_in = last ? '0 : left_ff - LEN_W'(1);
            if (last) begin
               phase_in = PH_CHANNEL;
            end
         end
         default: begin
            phase_in = PH_CHANNEL;
         end
      endcase
   end

   assign pop        = item.vld && (!emit || out_free);
   assign out_vld_in = (pop && emit) || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CHANNEL;
         chan_ff    <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (pop) begin
            phase_ff <= phase_in;
            chan_ff  <= chan_in;
            len_ff   <= len_in;
            left_ff  <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

   `LPFP_ASSERT(a_payload_has_bytes, (phase_ff == PH_PAYLOAD) |-> (left_ff != '0), "payload phase with no bytes left")
   `LPFP_ASSERT(a_empty_marker, (out_vld_ff && !out_ff.byte_valid) |-> (out_ff.frame_last && out_ff.payload_byte == '0 && out_ff.frame_length == '0), "malformed empty-frame marker")
   `LPFP_ASSERT_NEVER(a_no_overwrite, pop && emit && out_vld_ff && !rsp_ready, "result register overwritten")
   `LPFP_ASSERT(a_left_within_len, (phase_ff == PH_PAYLOAD) |-> (left_ff <= len_ff), "bytes left exceed frame length")

endmodule

>>> hdl/length_prefixed_frame_parser.sv
// Throughput: one byte per cycle while no result waits on rsp_ready; the input register
// refills as the parser drains it. Payload bytes pass the input then the result register.
// Header bytes give no transaction; payload bytes and empty-frame markers give one each.
// Reset (synchronous, active high) returns the parser to expecting a channel byte
// and empties both the input and the result register.
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Deframes channel / 16-bit length / payload byte streams into tagged bytes.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpfp_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lpfp_pkg::BYTE_W-1:0] rsp_channel,
   output logic [lpfp_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic                        rsp_byte_valid,
   output logic [lpfp_pkg::LEN_W-1:0]  rsp_frame_length,
   output logic                        rsp_frame_last
);
   import lpfp_pkg::*;

   item_type   item;
   result_type rsp;
   logic       pop;

   lpfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .pop         (pop),
      .item        (item)
   );

   lpfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_channel      = rsp.channel;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_byte_valid   = rsp.byte_valid;
   assign rsp_frame_length = rsp.frame_length;
   assign rsp_frame_last   = rsp.frame_last;

endmodule
